// ===== rtl/core/rtbc_pkg.sv =====
// Shared types and constants for the region table bounds checker.
package rtbc_pkg;

  localparam int SLOT_COUNT = 8;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int ADDR_W     = 48;
  localparam int DISK_W     = 32;

  typedef enum logic [2:0] {
    CMD_OPEN   = 3'd0,
    CMD_READ   = 3'd1,
    CMD_WRITE  = 3'd2,
    CMD_FORMAT = 3'd3,
    CMD_CLOSE  = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    STAT_OK          = 3'd0,
    STAT_INVALID     = 3'd1,
    STAT_NO_MEMORY   = 3'd2,
    STAT_EXISTS      = 3'd3,
    STAT_FULL        = 3'd4,
    STAT_NOT_FOUND   = 3'd5,
    STAT_OVERFLOW    = 3'd6,
    STAT_BAD_POINTER = 3'd7
  } status_t;

  typedef struct packed {
    logic [2:0]        command;
    logic [DISK_W-1:0] disk_number;
    logic [ADDR_W-1:0] address;
    logic [ADDR_W-1:0] length;
    logic [ADDR_W-1:0] buffer_address;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [ADDR_W-1:0] device_address;
    logic [ADDR_W-1:0] transfer_length;
  } out_item_t;

endpackage

// ===== rtl/core/region_table_bounds_checker.sv =====
// Region table with sequential slot scan and one shared add/subtract unit.
// After accept the item scans every slot in turn; open then runs the limit and length checks,
//   read and write also the buffer checks and the address sum; other commands go to the result.
//   A new item is taken only in idle; the slot scan (one slot per cycle) and add/subtract steps
//   (one per cycle) set the pace. A finished result may wait at the output while the next runs.
// Reset: synchronous; clears slot valid bits, the memory size register and the output valid.
module region_table_bounds_checker
  import rtbc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [ADDR_W-1:0] cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_CALC = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  typedef enum logic [4:0] {
    STEP_LIM  = 5'b00001,
    STEP_LEN1 = 5'b00010,
    STEP_BUF  = 5'b00100,
    STEP_LEN2 = 5'b01000,
    STEP_SUM  = 5'b10000
  } step_t;

  state_t            state_r;
  step_t             step_r;
  in_item_t          item_r;
  logic [ADDR_W-1:0] mem_size_r;
  logic [SLOT_W-1:0] idx_r;
  logic              found_r;
  logic [SLOT_W-1:0] hit_r;
  logic              free_found_r;
  logic [SLOT_W-1:0] free_r;
  logic [ADDR_W-1:0] hit_base_r;
  logic [ADDR_W-1:0] hit_len_r;
  logic [ADDR_W-1:0] diff_r;
  logic              borrow_r;
  logic              fit1_fail_r;
  logic              fit2_fail_r;
  logic [ADDR_W-1:0] sum_r;
  logic              out_valid_r;
  out_item_t         out_r;

  logic              slot_valid_r [SLOT_COUNT];
  logic [DISK_W-1:0] slot_disk_r  [SLOT_COUNT];
  logic [ADDR_W-1:0] slot_base_r  [SLOT_COUNT];
  logic [ADDR_W-1:0] slot_len_r   [SLOT_COUNT];

  logic              is_open;
  logic              is_rw;
  logic              scan_last;
  logic              scan_hit;
  logic              out_free;
  logic              finish;
  logic [ADDR_W-1:0] alu_a;
  logic [ADDR_W-1:0] alu_b;
  logic              alu_sub;
  logic [ADDR_W:0]   alu_res;
  logic              alu_borrow;
  out_item_t         res;
  logic              do_open;
  logic              do_close;

  assign is_open   = (item_r.command == CMD_OPEN);
  assign is_rw     = (item_r.command inside {CMD_READ, CMD_WRITE});
  assign scan_last = (idx_r == SLOT_W'(SLOT_COUNT - 1));
  assign scan_hit  = slot_valid_r[idx_r] && (slot_disk_r[idx_r] == item_r.disk_number);
  assign out_free  = !out_valid_r || !out_stall;
  assign finish    = (state_r == ST_FIN) && out_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Shared add/subtract unit
  always_comb begin
    case (step_r)
      STEP_LIM: begin
        alu_a   = is_open ? mem_size_r : hit_len_r;
        alu_b   = item_r.address;
        alu_sub = 1'b1;
      end
      STEP_BUF: begin
        alu_a   = mem_size_r;
        alu_b   = item_r.buffer_address;
        alu_sub = 1'b1;
      end
      STEP_SUM: begin
        alu_a   = hit_base_r;
        alu_b   = item_r.address;
        alu_sub = 1'b0;
      end
      default: begin
        alu_a   = diff_r;
        alu_b   = item_r.length;
        alu_sub = 1'b1;
      end
    endcase
  end

  assign alu_res    = {1'b0, alu_a} + {1'b0, alu_b ^ {ADDR_W{alu_sub}}} + {{ADDR_W{1'b0}}, alu_sub};
  assign alu_borrow = !alu_res[ADDR_W];

  // Result selection
  always_comb begin
    res      = '0;
    do_open  = 1'b0;
    do_close = 1'b0;
    case (cmd_t'(item_r.command))
      CMD_OPEN: begin
        if (item_r.length == '0 || item_r.address == '0) begin
          res.status = STAT_INVALID;
        end else if (fit1_fail_r) begin
          res.status = STAT_NO_MEMORY;
        end else if (found_r) begin
          res.status = STAT_EXISTS;
        end else if (!free_found_r) begin
          res.status = STAT_FULL;
        end else begin
          res.status = STAT_OK;
          do_open    = 1'b1;
        end
      end
      CMD_READ, CMD_WRITE: begin
        if (!found_r) begin
          res.status = STAT_NOT_FOUND;
        end else if (item_r.buffer_address == '0 || item_r.length == '0) begin
          res.status = STAT_INVALID;
        end else if (fit1_fail_r) begin
          res.status = STAT_OVERFLOW;
        end else if (fit2_fail_r) begin
          res.status = STAT_BAD_POINTER;
        end else begin
          res.status          = STAT_OK;
          res.device_address  = sum_r;
          res.transfer_length = item_r.length;
        end
      end
      CMD_FORMAT: begin
        if (!found_r) begin
          res.status = STAT_NOT_FOUND;
        end else begin
          res.status          = STAT_OK;
          res.device_address  = hit_base_r;
          res.transfer_length = hit_len_r;
        end
      end
      CMD_CLOSE: begin
        if (!found_r) begin
          res.status = STAT_NOT_FOUND;
        end else begin
          res.status = STAT_OK;
          do_close   = 1'b1;
        end
      end
      default: begin
        res.status = STAT_INVALID;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= STEP_LIM;
      mem_size_r  <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_valid_r[i] <= 1'b0;
      end
    end else begin
      if (cfg_we) begin
        mem_size_r <= cfg_data;
      end
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_last) begin
            step_r  <= STEP_LIM;
            state_r <= (is_open || is_rw) ? ST_CALC : ST_FIN;
          end
        end
        ST_CALC: begin
          case (step_r)
            STEP_LIM:  step_r <= STEP_LEN1;
            STEP_LEN1: begin
              if (is_open) begin
                state_r <= ST_FIN;
              end else begin
                step_r <= STEP_BUF;
              end
            end
            STEP_BUF:  step_r <= STEP_LEN2;
            STEP_LEN2: step_r <= STEP_SUM;
            default: begin
              state_r <= ST_FIN;
            end
          endcase
        end
        ST_FIN: begin
          if (out_free) begin
            state_r <= ST_IDLE;
            if (do_open) begin
              slot_valid_r[free_r] <= 1'b1;
            end
            if (do_close) begin
              slot_valid_r[hit_r] <= 1'b0;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath and table contents
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE) begin
      item_r       <= in_data;
      idx_r        <= '0;
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
    end
    if (state_r == ST_SCAN) begin
      if (scan_hit && !found_r) begin
        found_r    <= 1'b1;
        hit_r      <= idx_r;
        hit_base_r <= slot_base_r[idx_r];
        hit_len_r  <= slot_len_r[idx_r];
      end
      if (!slot_valid_r[idx_r] && !free_found_r) begin
        free_found_r <= 1'b1;
        free_r       <= idx_r;
      end
      if (!scan_last) begin
        idx_r <= idx_r + 1'b1;
      end
    end
    if (state_r == ST_CALC) begin
      case (step_r)
        STEP_LIM, STEP_BUF: begin
          diff_r   <= alu_res[ADDR_W-1:0];
          borrow_r <= alu_borrow;
        end
        STEP_LEN1: fit1_fail_r <= borrow_r || alu_borrow;
        STEP_LEN2: fit2_fail_r <= borrow_r || alu_borrow;
        default: begin
          sum_r <= alu_res[ADDR_W-1:0];
        end
      endcase
    end
    if (finish) begin
      out_r <= res;
      if (do_open) begin
        slot_disk_r[free_r] <= item_r.disk_number;
        slot_base_r[free_r] <= item_r.address;
        slot_len_r[free_r]  <= item_r.length;
      end
    end
  end

endmodule

// ===== rtl/core/rtbc_checker.sv =====
// Port-level assertions for the region table bounds checker, bound to the top level.
module rtbc_checker
  import rtbc_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input out_item_t         out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result item changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again before the item finished");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != STAT_OK) |->
      (out_data.device_address == '0) && (out_data.transfer_length == '0))
    else $error("failed command returned nonzero address or length");

endmodule

bind region_table_bounds_checker rtbc_checker u_rtbc_checker (.*);

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the region table bounds checker: directed table, then random traffic.
module tb_top;
  import rtbc_pkg::*;

  localparam logic [ADDR_W-1:0] ADDR_MAX = {ADDR_W{1'b1}};
  localparam logic [DISK_W-1:0] DISK_MAX = {DISK_W{1'b1}};
  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;
  localparam int GAP_MAX = 15;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 131;
  localparam int POOL_SIZE = 12;
  localparam int SETTLE_CYCLES = 2 * SLOT_COUNT + 8;
  localparam int REPORT_LIMIT = 10;
  localparam longint LIMIT_NS = 64'd10_000_000;

  typedef enum logic [1:0] {ROW_CFG, ROW_PREDICT, ROW_KNOWN} row_kind_t;

  typedef struct packed {
    row_kind_t kind;
    in_item_t  item;
    out_item_t result;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [ADDR_W-1:0] cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_item_t          in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_item_t         out_data;

  logic [ADDR_W-1:0] mem_size;
  logic              slot_used [SLOT_COUNT];
  logic [DISK_W-1:0] slot_disk [SLOT_COUNT];
  logic [ADDR_W-1:0] slot_start [SLOT_COUNT];
  logic [ADDR_W-1:0] slot_size [SLOT_COUNT];
  logic [DISK_W-1:0] disk_pool [POOL_SIZE];

  out_item_t region_results_q [$];
  stim_row_t stim_table [$];
  out_item_t want;
  int        mismatches = 0;
  int        send_left = 0;
  bit        send_quiet = 1'b0;
  int        take_left = 0;
  bit        take_quiet = 1'b0;

  region_table_bounds_checker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #(LIMIT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic bit span_fits(input logic [ADDR_W-1:0] start,
                                   input logic [ADDR_W-1:0] span,
                                   input logic [ADDR_W-1:0] limit);
    return (start <= limit) && (span <= limit - start);
  endfunction

  function automatic int find_region(input logic [DISK_W-1:0] disk);
    int hit;
    hit = -1;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (slot_used[i] && slot_disk[i] == disk) hit = i;
    end
    return hit;
  endfunction

  function automatic out_item_t region_predict(input in_item_t it);
    out_item_t res;
    int s;
    int free_slot;
    res = '0;
    res.status = STAT_INVALID;
    s = find_region(it.disk_number);
    free_slot = -1;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!slot_used[i]) free_slot = i;
    end
    case (it.command)
      CMD_OPEN: begin
        if (it.address == '0 || it.length == '0) begin
          res.status = STAT_INVALID;
        end else if (!span_fits(it.address, it.length, mem_size)) begin
          res.status = STAT_NO_MEMORY;
        end else if (s >= 0) begin
          res.status = STAT_EXISTS;
        end else if (free_slot < 0) begin
          res.status = STAT_FULL;
        end else begin
          slot_used[free_slot] = 1'b1;
          slot_disk[free_slot] = it.disk_number;
          slot_start[free_slot] = it.address;
          slot_size[free_slot] = it.length;
          res.status = STAT_OK;
        end
      end
      CMD_READ, CMD_WRITE: begin
        if (s < 0) begin
          res.status = STAT_NOT_FOUND;
        end else if (it.buffer_address == '0 || it.length == '0) begin
          res.status = STAT_INVALID;
        end else if (!span_fits(it.address, it.length, slot_size[s])) begin
          res.status = STAT_OVERFLOW;
        end else if (!span_fits(it.buffer_address, it.length, mem_size)) begin
          res.status = STAT_BAD_POINTER;
        end else begin
          res.status = STAT_OK;
          res.device_address = slot_start[s] + it.address;
          res.transfer_length = it.length;
        end
      end
      CMD_FORMAT: begin
        if (s < 0) begin
          res.status = STAT_NOT_FOUND;
        end else begin
          res.status = STAT_OK;
          res.device_address = slot_start[s];
          res.transfer_length = slot_size[s];
        end
      end
      CMD_CLOSE: begin
        if (s < 0) begin
          res.status = STAT_NOT_FOUND;
        end else begin
          slot_used[s] = 1'b0;
          slot_disk[s] = '0;
          slot_start[s] = '0;
          slot_size[s] = '0;
          res.status = STAT_OK;
        end
      end
      default: res.status = STAT_INVALID;
    endcase
    return res;
  endfunction

  function automatic int draw_gap(inout int left, inout bit quiet);
    if (left == 0) begin
      quiet = ($urandom_range(0, 3) == 0);
      left = $urandom_range(8, 40);
    end
    left--;
    return quiet ? 0 : $urandom_range(0, GAP_MAX);
  endfunction

  function automatic logic [ADDR_W-1:0] rand_addr();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[ADDR_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] pick_between(input logic [ADDR_W-1:0] lo,
                                                     input logic [ADDR_W-1:0] hi);
    logic [ADDR_W:0] span;
    logic [ADDR_W:0] r;
    span = {1'b0, hi} - {1'b0, lo} + 1'b1;
    r = {1'b0, rand_addr()};
    case ($urandom_range(0, 5))
      0: return lo;
      1: return hi;
      2: return ADDR_W'(lo + ($urandom_range(0, 63) % span));
      default: return ADDR_W'(lo + (r % span));
    endcase
  endfunction

  function automatic in_item_t gen_item();
    in_item_t it;
    int s;
    int pick;
    if ($urandom_range(0, 9) == 0) it.disk_number = $urandom;
    else it.disk_number = disk_pool[$urandom_range(0, POOL_SIZE - 1)];
    it.address = rand_addr();
    it.length = rand_addr();
    it.buffer_address = rand_addr();
    pick = $urandom_range(0, 99);
    if (pick < 25) it.command = CMD_OPEN;
    else if (pick < 48) it.command = CMD_READ;
    else if (pick < 71) it.command = CMD_WRITE;
    else if (pick < 81) it.command = CMD_FORMAT;
    else if (pick < 95) it.command = CMD_CLOSE;
    else it.command = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
    s = find_region(it.disk_number);
    if ($urandom_range(0, 4) != 0) begin
      if (it.command == CMD_OPEN && mem_size > 1) begin
        it.address = pick_between(48'd1, mem_size - 48'd1);
        it.length = pick_between(48'd1, mem_size - it.address);
      end else if ((it.command == CMD_READ || it.command == CMD_WRITE) && s >= 0) begin
        it.address = pick_between('0, slot_size[s] - 48'd1);
        it.length = pick_between(48'd1, slot_size[s] - it.address);
        if (mem_size > it.length) it.buffer_address = pick_between(48'd1, mem_size - it.length);
      end
    end else begin
      case ($urandom_range(0, 5))
        0: it.address = '0;
        1: it.length = '0;
        2: it.buffer_address = '0;
        3: begin
          if (s >= 0) begin
            it.length = pick_between(48'd1, slot_size[s]);
            it.address = slot_size[s] - it.length + 1'b1;
          end
        end
        4: begin
          it.length = pick_between(48'd1, 48'hFFFF);
          it.address = mem_size - it.length + 1'b1;
          it.buffer_address = it.address;
        end
        default: ;
      endcase
    end
    return it;
  endfunction

  function automatic void add_row(input row_kind_t kind, input logic [2:0] cmd,
                                  input logic [DISK_W-1:0] disk,
                                  input logic [ADDR_W-1:0] addr, input logic [ADDR_W-1:0] len,
                                  input logic [ADDR_W-1:0] buf_addr, input logic [2:0] st,
                                  input logic [ADDR_W-1:0] dev, input logic [ADDR_W-1:0] xfer);
    stim_row_t row;
    row.kind = kind;
    row.item.command = cmd;
    row.item.disk_number = disk;
    row.item.address = addr;
    row.item.length = len;
    row.item.buffer_address = buf_addr;
    row.result.status = st;
    row.result.device_address = dev;
    row.result.transfer_length = xfer;
    stim_table.push_back(row);
  endfunction

  task automatic send_item(input in_item_t it, input bit known, input out_item_t known_result);
    int gap;
    out_item_t predicted;
    gap = draw_gap(send_left, send_quiet);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    predicted = region_predict(it);
    region_results_q.push_back(known ? known_result : predicted);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (region_results_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_mem_limit(input logic [ADDR_W-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    mem_size = value;
  endtask

  initial begin : result_sink
    int gap;
    forever begin
      gap = draw_gap(take_left, take_quiet);
      @(negedge clk);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (region_results_q.size() == 0) begin
        if (mismatches < REPORT_LIMIT) begin
          $display("unexpected item: status=%0d dev=%h len=%h",
                   out_data.status, out_data.device_address, out_data.transfer_length);
        end
        mismatches++;
      end else begin
        want = region_results_q.pop_front();
        if (out_data.status !== want.status ||
            out_data.device_address !== want.device_address ||
            out_data.transfer_length !== want.transfer_length) begin
          if (mismatches < REPORT_LIMIT) begin
            $display("mismatch: exp status=%0d dev=%h len=%h, got status=%0d dev=%h len=%h",
                     want.status, want.device_address, want.transfer_length,
                     out_data.status, out_data.device_address, out_data.transfer_length);
          end
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    stim_row_t row;
    logic [ADDR_W-1:0] phase_size;
    mem_size = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      slot_used[i] = 1'b0;
      slot_disk[i] = '0;
      slot_start[i] = '0;
      slot_size[i] = '0;
    end

    add_row(ROW_KNOWN, CMD_OPEN, 32'd1, 48'd1, 48'd1, 48'd0, STAT_NO_MEMORY, '0, '0);
    add_row(ROW_KNOWN, CMD_READ, 32'd1, 48'd0, 48'd1, 48'd1, STAT_NOT_FOUND, '0, '0);
    add_row(ROW_KNOWN, CMD_SPARE_HI, 32'd1, 48'd1, 48'd1, 48'd1, STAT_INVALID, '0, '0);
    add_row(ROW_CFG, CMD_OPEN, '0, ADDR_MAX, '0, '0, STAT_OK, '0, '0);
    add_row(ROW_KNOWN, CMD_OPEN, 32'd0, 48'd0, 48'd5, 48'd0, STAT_INVALID, '0, '0);
    add_row(ROW_KNOWN, CMD_OPEN, 32'd0, 48'd5, 48'd0, 48'd0, STAT_INVALID, '0, '0);
    add_row(ROW_KNOWN, CMD_OPEN, DISK_MAX, 48'd1, ADDR_MAX, 48'd0, STAT_NO_MEMORY, '0, '0);
    add_row(ROW_KNOWN, CMD_OPEN, DISK_MAX, ADDR_MAX, 48'd1, 48'd0, STAT_NO_MEMORY, '0, '0);
    add_row(ROW_KNOWN, CMD_OPEN, DISK_MAX, 48'd1, ADDR_MAX - 48'd1, 48'd0, STAT_OK, '0, '0);
    add_row(ROW_KNOWN, CMD_OPEN, DISK_MAX, 48'd2, 48'd3, 48'd0, STAT_EXISTS, '0, '0);
    add_row(ROW_KNOWN, CMD_FORMAT, DISK_MAX, 48'd0, 48'd0, 48'd0, STAT_OK,
            48'd1, ADDR_MAX - 48'd1);
    add_row(ROW_KNOWN, CMD_READ, DISK_MAX, 48'd0, ADDR_MAX - 48'd1, 48'd1, STAT_OK,
            48'd1, ADDR_MAX - 48'd1);
    add_row(ROW_KNOWN, CMD_WRITE, DISK_MAX, 48'd1, ADDR_MAX - 48'd1, 48'd1, STAT_OVERFLOW,
            '0, '0);
    add_row(ROW_KNOWN, CMD_WRITE, DISK_MAX, 48'd0, 48'd4, 48'd0, STAT_INVALID, '0, '0);
    add_row(ROW_KNOWN, CMD_READ, DISK_MAX, 48'd0, 48'd0, 48'd4, STAT_INVALID, '0, '0);
    add_row(ROW_KNOWN, CMD_READ, DISK_MAX, ADDR_MAX, 48'd1, 48'd1, STAT_OVERFLOW, '0, '0);
    add_row(ROW_KNOWN, CMD_WRITE, DISK_MAX, 48'd0, 48'd4, ADDR_MAX, STAT_BAD_POINTER,
            '0, '0);
    for (int k = 0; k < SLOT_COUNT - 1; k++) begin
      add_row(ROW_PREDICT, CMD_OPEN, k, 48'h1000 * (k + 1), 48'h1000, 48'd0, STAT_OK, '0, '0);
    end
    add_row(ROW_KNOWN, CMD_OPEN, 32'd99, 48'd1, 48'd1, 48'd0, STAT_FULL, '0, '0);
    add_row(ROW_KNOWN, CMD_CLOSE, DISK_MAX, 48'd0, 48'd0, 48'd0, STAT_OK, '0, '0);
    add_row(ROW_KNOWN, CMD_CLOSE, DISK_MAX, 48'd0, 48'd0, 48'd0, STAT_NOT_FOUND, '0, '0);
    add_row(ROW_KNOWN, CMD_SPARE_LO, 32'd0, 48'd0, 48'd0, 48'd0, STAT_INVALID, '0, '0);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (stim_table[i]) begin
      row = stim_table[i];
      if (row.kind == ROW_CFG) write_mem_limit(row.item.address);
      else send_item(row.item, row.kind == ROW_KNOWN, row.result);
    end

    disk_pool[0] = '0;
    disk_pool[1] = DISK_MAX;
    for (int i = 2; i < POOL_SIZE; i++) disk_pool[i] = $urandom;

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: phase_size = ADDR_MAX;
        1: phase_size = rand_addr();
        2: phase_size = 48'h1_0000;
        3: phase_size = '0;
        4: phase_size = rand_addr() >> $urandom_range(0, 40);
        5: phase_size = 48'hFFFF_FFFF;
        6: phase_size = 48'd64;
        default: phase_size = ADDR_MAX;
      endcase
      write_mem_limit(phase_size);
      repeat (PHASE_ITEMS) send_item(gen_item(), 1'b0, '0);
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && region_results_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/rtbc_pkg.sv
rtl/core/region_table_bounds_checker.sv
rtl/core/rtbc_checker.sv
bench/tb_top.sv
